// ===== design/mbrs_pkg.sv =====
// Shared constants, types and the CRC-16 byte step for the Modbus RTU slave responder.
package mbrs_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int STORE_DEPTH = FRAME_BYTES - 1;
    localparam int JOB_BYTES   = FRAME_BYTES - 2;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [POS_W-1:0] POS_FUNC   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_WRITE      = 8'h06;
    localparam logic [7:0] FUNC_READ       = 8'h03;
    localparam logic [7:0] READ_BYTE_COUNT = 8'h02;

    // Reply data bytes before the two CRC bytes.
    localparam logic [IDX_W-1:0] WRITE_DATA_BYTES = IDX_W'(JOB_BYTES);
    localparam logic [IDX_W-1:0] READ_DATA_BYTES  = IDX_W'(5);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ADDR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_ADDR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_VALUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_VALUE = 3'd4;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] motor_register_address;
        logic [15:0] switch_register_address;
        logic [15:0] motor_status_value;
        logic [15:0] switch_status_value;
    } cfg_t;

    // One pending reply: its data bytes and whether it is a read reply.
    typedef struct packed {
        logic                      is_read;
        logic [JOB_BYTES-1:0][7:0] data;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/modbus_rtu_slave_responder.sv =====
// Top level of the Modbus RTU slave responder: configuration registers and the reply chain.
//
//   Channel   Signals                          Direction
//   rx        rx_valid, rx_stall, rx_byte      in (rx_stall driven here)
//   tx        tx_valid, tx_stall, tx_byte,     out (tx_stall driven by sink)
//             last_byte
//   cfg       cfg_write, cfg_index, cfg_data   in
//
// A received byte is taken every cycle while rx_stall is low; rx_stall rises only while
// two checked replies wait. A reply leaves one byte per cycle through the output register
// while tx_stall is low. The closing request byte pushes the job into the queue, the
// sender loads the job from the queue, and the first byte is then registered for output.
// Reset clears the frame position, the CRC, the queue, the sender and the output valid.
// A stall on tx holds the output byte and, once the queue fills, backs up onto rx.
module modbus_rtu_slave_responder
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mbrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbrs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               rx_valid,
    output logic                               rx_stall,
    input  logic [7:0]                         rx_byte,
    output logic                               tx_valid,
    input  logic                               tx_stall,
    output logic [7:0]                         tx_byte,
    output logic                               last_byte
);

    mbrs_pkg::cfg_t cfg_reg;
    logic           rx_accept;
    logic           job_push;
    mbrs_pkg::job_t front_job;
    mbrs_pkg::job_t queue_job;
    logic           queue_not_empty;
    logic           queue_full;
    logic           job_pop;
    logic           back_busy;

    assign rx_stall  = queue_full;
    assign rx_accept = rx_valid && !rx_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address           <= 8'd1;
            cfg_reg.motor_register_address  <= 16'd0;
            cfg_reg.switch_register_address <= 16'd1;
            cfg_reg.motor_status_value      <= 16'd0;
            cfg_reg.switch_status_value     <= 16'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mbrs_pkg::CFG_SLAVE_ADDR:   cfg_reg.slave_address           <= cfg_data[7:0];
                mbrs_pkg::CFG_MOTOR_ADDR:   cfg_reg.motor_register_address  <= cfg_data;
                mbrs_pkg::CFG_SWITCH_ADDR:  cfg_reg.switch_register_address <= cfg_data;
                mbrs_pkg::CFG_MOTOR_VALUE:  cfg_reg.motor_status_value      <= cfg_data;
                mbrs_pkg::CFG_SWITCH_VALUE: cfg_reg.switch_status_value     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mbrs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (rx_accept),
        .rx_byte  (rx_byte),
        .cfg      (cfg_reg),
        .job_push (job_push),
        .job      (front_job)
    );

    mbrs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .job_in    (front_job),
        .pop       (job_pop),
        .not_empty (queue_not_empty),
        .full      (queue_full),
        .job_out   (queue_job)
    );

    mbrs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_not_empty),
        .job_in    (queue_job),
        .job_pop   (job_pop),
        .busy      (back_busy),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_byte   (tx_byte),
        .last_byte (last_byte)
    );

`ifndef SYNTH
    // A checked reply is never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !queue_full)
        else $error("reply job pushed into a full queue");

    // The sender only loads a new job once the previous reply is finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !back_busy && queue_not_empty)
        else $error("job popped while the sender is busy or the queue is empty");

    // The closing byte of a reply ends the sender's run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid && last_byte && !$stable(tx_byte)) |-> !back_busy || $rose(back_busy))
        else $error("sender still busy after the closing reply byte");
`endif

endmodule

// ===== design/mbrs_front.sv =====
// Front end: assembles request frames, checks address, function and CRC, builds reply jobs.
module mbrs_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  mbrs_pkg::cfg_t      cfg,
    output logic                job_push,
    output mbrs_pkg::job_t      job
);

    logic [7:0]                  store_reg [mbrs_pkg::STORE_DEPTH];
    logic [mbrs_pkg::POS_W-1:0]  pos_reg;
    logic [mbrs_pkg::POS_W-1:0]  pos_next;
    logic [15:0]                 crc_reg;
    logic [15:0]                 crc_next;
    logic                        header_bad;
    logic                        crc_ok;
    logic [15:0]                 reg_addr;
    logic                        is_write;
    logic                        motor_hit;
    logic                        switch_hit;
    logic [15:0]                 value;

    assign header_bad = (store_reg[0] != cfg.slave_address)
                     || ((rx_byte != mbrs_pkg::FUNC_WRITE) && (rx_byte != mbrs_pkg::FUNC_READ));
    assign crc_ok     = ({rx_byte, store_reg[mbrs_pkg::POS_CRC_LO]} == crc_reg);
    assign reg_addr   = {store_reg[2], store_reg[3]};
    assign is_write   = (store_reg[1] == mbrs_pkg::FUNC_WRITE);
    assign motor_hit  = (reg_addr == cfg.motor_register_address);
    assign switch_hit = (reg_addr == cfg.switch_register_address);
    assign value      = motor_hit ? cfg.motor_status_value : cfg.switch_status_value;

    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        job_push = 1'b0;
        if (accept)
        begin
            priority if ((pos_reg == mbrs_pkg::POS_FUNC) && header_bad)
            begin
                pos_next = '0;
                crc_next = mbrs_pkg::CRC_INIT;
            end
            else if (pos_reg == mbrs_pkg::POS_LAST)
            begin
                pos_next = '0;
                crc_next = mbrs_pkg::CRC_INIT;
                job_push = crc_ok && (is_write || motor_hit || switch_hit);
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg < mbrs_pkg::POS_CRC_LO)
                begin
                    crc_next = mbrs_pkg::crc_byte(crc_reg, rx_byte);
                end
            end
        end
    end

    always_comb
    begin
        job.is_read = !is_write;
        for (int i = 0; i < mbrs_pkg::JOB_BYTES; i++)
        begin
            job.data[i] = store_reg[i];
        end
        if (!is_write)
        begin
            job.data[0] = cfg.slave_address;
            job.data[1] = mbrs_pkg::FUNC_READ;
            job.data[2] = mbrs_pkg::READ_BYTE_COUNT;
            job.data[3] = value[15:8];
            job.data[4] = value[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= mbrs_pkg::CRC_INIT;
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    // The final byte is never stored; its value is used directly in the CRC compare.
    always_ff @(posedge clk)
    begin
        if (accept && (pos_reg != mbrs_pkg::POS_LAST))
        begin
            store_reg[pos_reg] <= rx_byte;
        end
    end

endmodule

// ===== design/mbrs_queue.sv =====
// Two-entry job queue between the frame checker and the reply sender.
module mbrs_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbrs_pkg::job_t  job_in,
    input  logic            pop,
    output logic            not_empty,
    output logic            full,
    output mbrs_pkg::job_t  job_out
);

    localparam int PTR_W = $clog2(mbrs_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mbrs_pkg::QUEUE_DEPTH + 1);

    mbrs_pkg::job_t   entry_reg [mbrs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(mbrs_pkg::QUEUE_DEPTH));
    assign job_out   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

// ===== design/mbrs_back.sv =====
// Back end: sends reply bytes one per cycle unless tx_stall holds them, and appends the CRC, low byte first.
module mbrs_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  mbrs_pkg::job_t  job_in,
    output logic            job_pop,
    output logic            busy,
    output logic            tx_valid,
    input  logic            tx_stall,
    output logic [7:0]      tx_byte,
    output logic            last_byte
);

    localparam int IDX_W = mbrs_pkg::IDX_W;

    logic                busy_reg;
    logic                busy_next;
    mbrs_pkg::job_t      job_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [15:0]         crc_reg;
    logic [15:0]         crc_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          out_byte_reg;
    logic [7:0]          out_byte_next;
    logic                out_last_reg;
    logic                out_last_next;
    logic                advance;
    logic [IDX_W-1:0]    data_bytes;

    assign advance    = !out_valid_reg || !tx_stall;
    assign data_bytes = job_reg.is_read ? mbrs_pkg::READ_DATA_BYTES
                                        : mbrs_pkg::WRITE_DATA_BYTES;
    assign job_pop    = !busy_reg && job_valid;
    assign busy       = busy_reg;
    assign tx_valid   = out_valid_reg;
    assign tx_byte    = out_byte_reg;
    assign last_byte  = out_last_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && tx_stall;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (!busy_reg)
        begin
            if (job_valid)
            begin
                busy_next = 1'b1;
                idx_next  = '0;
                crc_next  = mbrs_pkg::CRC_INIT;
            end
        end
        else if (advance)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            priority if (idx_reg < data_bytes)
            begin
                out_byte_next = job_reg.data[idx_reg];
                crc_next      = mbrs_pkg::crc_byte(crc_reg, job_reg.data[idx_reg]);
                idx_next      = idx_reg + 1'b1;
            end
            else if (idx_reg == data_bytes)
            begin
                out_byte_next = crc_reg[7:0];
                idx_next      = idx_reg + 1'b1;
            end
            else
            begin
                out_byte_next = crc_reg[15:8];
                out_last_next = 1'b1;
                busy_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job_in;
        end
        idx_reg      <= idx_next;
        crc_reg      <= crc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the Modbus RTU slave responder: request frames in, replies checked.
module testbench;

    localparam int RUN_LIMIT   = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 16;
    localparam int PHASE_BYTES = 58;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } reply_byte_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                            cfg_write = 1'b0;
    logic [mbrs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mbrs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            rx_valid  = 1'b0;
    logic                            rx_stall;
    logic [7:0]                      rx_byte   = 8'h00;
    logic                            tx_valid;
    logic                            tx_stall  = 1'b0;
    logic [7:0]                      tx_byte;
    logic                            last_byte;

    modbus_rtu_slave_responder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_byte   (tx_byte),
        .last_byte (last_byte)
    );

    // Bench copy of the configuration and of the frame assembly state.
    logic [7:0]                 cfg_slave       = 8'h01;
    logic [15:0]                cfg_motor_addr  = 16'h0000;
    logic [15:0]                cfg_switch_addr = 16'h0001;
    logic [15:0]                cfg_motor_val   = 16'h0000;
    logic [15:0]                cfg_switch_val  = 16'h0000;
    logic [7:0]                 frame_buf [0:mbrs_pkg::FRAME_BYTES-1];
    logic [mbrs_pkg::POS_W-1:0] frame_pos = '0;
    logic [15:0]                crc_acc   = mbrs_pkg::CRC_INIT;

    logic [7:0]  rx_pending [$];
    reply_byte_t reply_bytes [$];

    int unsigned stall_pct = 0;
    int unsigned gap_max   = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned stall_run  = 0;
    bit          stall_on   = 1'b0;
    bit          hold_arm   = 1'b0;
    int unsigned hold_left  = 0;

    int unsigned bytes_sent = 0;
    int unsigned write_echoes = 0;
    int unsigned read_replies = 0;
    int unsigned unknown_reads = 0;
    int unsigned pairs_dropped = 0;
    int unsigned crc_drops = 0;
    int unsigned frames_seen = 0;
    int unsigned backpressure_cycles = 0;
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ mbrs_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic expect_byte(input logic [7:0] b, input logic is_last);
        reply_byte_t e;
        e.data    = b;
        e.is_last = is_last;
        reply_bytes.push_back(e);
    endtask

    // Advances the frame assembly by one received byte and queues the reply it completes.
    task automatic predict_reply(input logic [7:0] b);
        logic [15:0] closing_crc;
        logic [15:0] reg_addr;
        logic [15:0] word;
        logic [15:0] acc;
        logic [7:0]  hdr [0:4];
        bit          hit;
        int          i;
        frame_buf[frame_pos] = b;
        if (frame_pos < mbrs_pkg::POS_CRC_LO)
        begin
            crc_acc = crc16_update(crc_acc, b);
        end
        if (frame_pos == mbrs_pkg::POS_FUNC && (frame_buf[0] != cfg_slave ||
            (frame_buf[1] != mbrs_pkg::FUNC_WRITE && frame_buf[1] != mbrs_pkg::FUNC_READ)))
        begin
            pairs_dropped++;
            frame_pos = '0;
            crc_acc   = mbrs_pkg::CRC_INIT;
        end
        else if (frame_pos != mbrs_pkg::POS_LAST)
        begin
            frame_pos = frame_pos + 1'b1;
        end
        else
        begin
            frames_seen++;
            closing_crc = crc_acc;
            frame_pos   = '0;
            crc_acc     = mbrs_pkg::CRC_INIT;
            if ({frame_buf[mbrs_pkg::POS_LAST], frame_buf[mbrs_pkg::POS_CRC_LO]} != closing_crc)
            begin
                crc_drops++;
            end
            else if (frame_buf[1] == mbrs_pkg::FUNC_WRITE)
            begin
                for (i = 0; i < mbrs_pkg::JOB_BYTES; i++)
                begin
                    expect_byte(frame_buf[i], 1'b0);
                end
                expect_byte(closing_crc[7:0], 1'b0);
                expect_byte(closing_crc[15:8], 1'b1);
                write_echoes++;
            end
            else
            begin
                reg_addr = {frame_buf[2], frame_buf[3]};
                hit  = 1'b1;
                word = 16'h0000;
                // The motor register is checked first, so it wins when both addresses match.
                if (reg_addr == cfg_motor_addr)
                begin
                    word = cfg_motor_val;
                end
                else if (reg_addr == cfg_switch_addr)
                begin
                    word = cfg_switch_val;
                end
                else
                begin
                    hit = 1'b0;
                end
                if (!hit)
                begin
                    unknown_reads++;
                end
                else
                begin
                    hdr[0] = cfg_slave;
                    hdr[1] = mbrs_pkg::FUNC_READ;
                    hdr[2] = mbrs_pkg::READ_BYTE_COUNT;
                    hdr[3] = word[15:8];
                    hdr[4] = word[7:0];
                    acc = mbrs_pkg::CRC_INIT;
                    for (i = 0; i < int'(mbrs_pkg::READ_DATA_BYTES); i++)
                    begin
                        acc = crc16_update(acc, hdr[i]);
                        expect_byte(hdr[i], 1'b0);
                    end
                    expect_byte(acc[7:0], 1'b0);
                    expect_byte(acc[15:8], 1'b1);
                    read_replies++;
                end
            end
        end
    endtask

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end
        else if (rx_valid && rx_stall)
        begin
            backpressure_cycles++;
        end
        else
        begin
            if (rx_valid)
            begin
                predict_reply(rx_byte);
                rx_pending.delete(0);
                bytes_sent++;
            end
            if (gap_left != 0)
            begin
                gap_left--;
                rx_valid <= 1'b0;
            end
            else if (rx_pending.size() != 0)
            begin
                rx_valid <= 1'b1;
                rx_byte  <= rx_pending[0];
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
            end
            else
            begin
                rx_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, armed once by the stimulus process.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_arm)
        begin
            hold_arm = 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks each reply transaction and stalls in runs of random length.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_stall <= 1'b0;
        end
        else
        begin
            if (tx_valid && !tx_stall)
            begin
                if (reply_bytes.size() == 0)
                begin
                    report_fault($sformatf("unexpected reply byte %02h last %0d",
                                           tx_byte, last_byte));
                end
                else
                begin
                    if (tx_byte !== reply_bytes[0].data)
                    begin
                        report_fault($sformatf("tx_byte: expected %02h got %02h",
                                               reply_bytes[0].data, tx_byte));
                    end
                    if (last_byte !== reply_bytes[0].is_last)
                    begin
                        report_fault($sformatf("last_byte: expected %0d got %0d",
                                               reply_bytes[0].is_last, last_byte));
                    end
                    reply_bytes.delete(0);
                end
            end
            if (stall_run == 0)
            begin
                stall_on  = ($urandom_range(0, 99) < stall_pct);
                stall_run = $urandom_range(1, 6);
            end
            stall_run--;
            tx_stall <= (hold_left != 0) || stall_on;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reply bytes outstanding",
                     RUN_LIMIT, reply_bytes.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input logic [mbrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            mbrs_pkg::CFG_SLAVE_ADDR:   cfg_slave       = value[7:0];
            mbrs_pkg::CFG_MOTOR_ADDR:   cfg_motor_addr  = value;
            mbrs_pkg::CFG_SWITCH_ADDR:  cfg_switch_addr = value;
            mbrs_pkg::CFG_MOTOR_VALUE:  cfg_motor_val   = value;
            mbrs_pkg::CFG_SWITCH_VALUE: cfg_switch_val  = value;
            default: ;
        endcase
    endtask

    task automatic program_settings(input logic [7:0] slave, input logic [15:0] motor_addr,
                                    input logic [15:0] switch_addr, input logic [15:0] motor_val,
                                    input logic [15:0] switch_val);
        write_reg(mbrs_pkg::CFG_SLAVE_ADDR, {8'h00, slave});
        write_reg(mbrs_pkg::CFG_MOTOR_ADDR, motor_addr);
        write_reg(mbrs_pkg::CFG_SWITCH_ADDR, switch_addr);
        write_reg(mbrs_pkg::CFG_MOTOR_VALUE, motor_val);
        write_reg(mbrs_pkg::CFG_SWITCH_VALUE, switch_val);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Queues a full request frame; crc_flip corrupts the trailing CRC when nonzero.
    task automatic push_request(input logic [7:0] addr, input logic [7:0] func,
                                input logic [15:0] reg_addr, input logic [15:0] word,
                                input logic [15:0] crc_flip);
        logic [7:0]  body [0:5];
        logic [15:0] acc;
        int          i;
        body[0] = addr;
        body[1] = func;
        body[2] = reg_addr[15:8];
        body[3] = reg_addr[7:0];
        body[4] = word[15:8];
        body[5] = word[7:0];
        acc = mbrs_pkg::CRC_INIT;
        for (i = 0; i < mbrs_pkg::JOB_BYTES; i++)
        begin
            acc = crc16_update(acc, body[i]);
            rx_pending.push_back(body[i]);
        end
        acc = acc ^ crc_flip;
        rx_pending.push_back(acc[7:0]);
        rx_pending.push_back(acc[15:8]);
    endtask

    task automatic push_random_frame();
        int unsigned pick;
        int unsigned which;
        int          i;
        logic [15:0] reg_addr;
        logic [15:0] word;
        logic [7:0]  func;
        pick  = $urandom_range(0, 99);
        word  = 16'($urandom);
        func  = $urandom_range(0, 1) ? mbrs_pkg::FUNC_READ : mbrs_pkg::FUNC_WRITE;
        which = $urandom_range(0, 9);
        if (which < 4)
        begin
            reg_addr = cfg_motor_addr;
        end
        else if (which < 8)
        begin
            reg_addr = cfg_switch_addr;
        end
        else
        begin
            reg_addr = 16'($urandom);
        end
        if (pick < 35)
        begin
            push_request(cfg_slave, mbrs_pkg::FUNC_READ, reg_addr, word, 16'h0000);
        end
        else if (pick < 60)
        begin
            push_request(cfg_slave, mbrs_pkg::FUNC_WRITE, 16'($urandom), word, 16'h0000);
        end
        else if (pick < 72)
        begin
            push_request(cfg_slave, func, reg_addr, word, 16'(1 << $urandom_range(0, 15)));
        end
        else if (pick < 80)
        begin
            rx_pending.push_back(cfg_slave ^ 8'($urandom_range(1, 255)));
            rx_pending.push_back(func);
        end
        else if (pick < 86)
        begin
            do
            begin
                func = 8'($urandom);
            end
            while (func == mbrs_pkg::FUNC_READ || func == mbrs_pkg::FUNC_WRITE);
            rx_pending.push_back(cfg_slave);
            rx_pending.push_back(func);
        end
        else if (pick < 92)
        begin
            // Valid header followed by random bytes: almost always a CRC failure.
            rx_pending.push_back(cfg_slave);
            rx_pending.push_back(func);
            for (i = 0; i < mbrs_pkg::JOB_BYTES; i++)
            begin
                rx_pending.push_back(8'($urandom));
            end
        end
        else
        begin
            rx_pending.push_back(8'($urandom));
            rx_pending.push_back(8'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (rx_pending.size() != 0 || reply_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        logic [15:0] shared_addr;
        int          phase;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        program_settings(8'h01, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        @(negedge clk);
        stall_pct = 25;
        gap_max   = 3;
        push_request(8'h01, mbrs_pkg::FUNC_WRITE, 16'hFFFF, 16'h0000, 16'h0000);
        push_request(8'h01, mbrs_pkg::FUNC_READ, 16'h0000, 16'h0001, 16'h0000);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(mbrs_pkg::FUNC_READ);
        rx_pending.push_back(8'h01);
        rx_pending.push_back(8'hFF);
        push_request(8'h01, mbrs_pkg::FUNC_WRITE, 16'h1234, 16'h5678, 16'h0100);
        wait_idle();

        for (phase = 1; phase <= 5; phase++)
        begin
            case (phase)
                1: program_settings(8'h00, 16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom));
                2:
                begin
                    shared_addr = 16'($urandom);
                    program_settings(8'hFF, shared_addr, shared_addr, 16'hFFFF, 16'h0000);
                end
                3: program_settings(8'($urandom), 16'($urandom), 16'($urandom),
                                    16'h0000, 16'hFFFF);
                default: program_settings(8'($urandom), 16'($urandom), 16'($urandom),
                                          16'($urandom), 16'($urandom));
            endcase
            @(negedge clk);
            case (phase)
                1: begin stall_pct = 30; gap_max = 6;  end
                2: begin stall_pct = 20; gap_max = 1;  end
                3: begin stall_pct = 60; gap_max = 10; end
                4: begin stall_pct = 0;  gap_max = 0;  end
                default: begin stall_pct = 40; gap_max = 4; end
            endcase
            // With equal register addresses and the receiver held off, replies pile up
            // until the block has to stall its input.
            if (phase == 2)
            begin
                hold_arm = 1'b1;
            end
            while (rx_pending.size() < PHASE_BYTES)
            begin
                push_random_frame();
            end
            wait_idle();
        end

        $display("sent %0d request bytes over 6 register settings: %0d frames, %0d write echoes,",
                 bytes_sent, frames_seen, write_echoes);
        $display("%0d read replies, %0d unanswered reads, %0d header pairs and %0d bad CRC frames",
                 read_replies, unknown_reads, pairs_dropped, crc_drops);
        $display("input stalled for %0d cycles", backpressure_cycles);
        if (fault_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("%0d mismatches in total", fault_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
